### rtl/lwgh_pkg.sv
// ----------------------------------------------------------------------------
// lwgh_pkg
// shared constants, register codes and inter-stage types of the widest-gap
// heading finder
// ----------------------------------------------------------------------------
package lwgh_pkg;

	localparam int WINDOW   = 300;
	localparam int HALF     = WINDOW / 2;
	localparam int MAX_SCAN = 4096;

	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int CNT_W   = $clog2(MAX_SCAN + 1);
	localparam int IDX_W   = 12;
	localparam int RANGE_W = 16;
	localparam int PROD_W  = 2 * RANGE_W;
	localparam int AMIN_W  = 19;
	localparam int STEP_W  = 16;
	localparam int CFG_W   = 19;
	localparam int HSUM_W  = 13;
	localparam int MULT_W  = HSUM_W + STEP_W;
	localparam int HEAD_W  = MULT_W + 5;
	localparam int OUT_W   = 32;

	localparam logic [AMIN_W-1:0]  AMIN_RST = AMIN_W'(-205887);
	localparam logic [STEP_W-1:0]  STEP_RST = STEP_W'(286);
	localparam logic [RANGE_W-1:0] SAFE_RST = RANGE_W'(500);

	localparam logic signed [HEAD_W-1:0] SAT_MAX = {{(HEAD_W-OUT_W+1){1'b0}},
		{(OUT_W-1){1'b1}}};
	localparam logic signed [HEAD_W-1:0] SAT_MIN = {{(HEAD_W-OUT_W+1){1'b1}},
		{(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CFG_BASE_ANGLE = 2'd0,
		CFG_ANGLE_STEP = 2'd1,
		CFG_SAFE_DIST  = 2'd2,
		CFG_COS_POS    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [AMIN_W-1:0]  base_angle;
		logic [STEP_W-1:0]  angle_step;
		logic [RANGE_W-1:0] clear_range;
		logic               cos_pos;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               last;
		logic               pair;
		logic [IDX_W-1:0]   idx;
		logic [RANGE_W-1:0] sample;
	} samp_t;

	typedef struct packed {
		logic               valid;
		logic               found;
		logic [IDX_W-1:0]   idx;
		logic [RANGE_W-1:0] mid;
	} res_t;

endpackage

### rtl/lwgh_front.sv
// ----------------------------------------------------------------------------
// lwgh_front
// scan position counters and the range delay line; reads the pair partner
// and the midpoint sample while writing the new sample
// ----------------------------------------------------------------------------
module lwgh_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          accept,
	input  logic [lwgh_pkg::RANGE_W-1:0]  range_mm,
	input  logic                          last_in_scan,
	output lwgh_pkg::samp_t               samp_s1,
	output logic [lwgh_pkg::RANGE_W-1:0]  first_s1,
	output logic [lwgh_pkg::RANGE_W-1:0]  mid_s1
);

	logic [lwgh_pkg::CNT_W-1:0]   cnt_q;
	logic [lwgh_pkg::SLOT_W-1:0]  slot_q;
	logic [lwgh_pkg::SLOT_W-1:0]  mid_q;
	logic [lwgh_pkg::RANGE_W-1:0] mem [lwgh_pkg::WINDOW];
	logic                         in_scan;
	logic                         pair;
	logic                         valid_s1;
	logic                         last_s1;
	logic                         pair_s1;
	logic [lwgh_pkg::IDX_W-1:0]   idx_s1;
	logic [lwgh_pkg::RANGE_W-1:0] sample_s1;

	assign in_scan = cnt_q < lwgh_pkg::CNT_W'(lwgh_pkg::MAX_SCAN);
	assign pair    = in_scan && (cnt_q >= lwgh_pkg::CNT_W'(lwgh_pkg::WINDOW));
	assign samp_s1 = {valid_s1, last_s1, pair_s1, idx_s1, sample_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			slot_q <= '0;
			mid_q  <= lwgh_pkg::SLOT_W'(lwgh_pkg::WINDOW - lwgh_pkg::HALF);
		end else if (accept) begin
			if (last_in_scan) begin
				cnt_q  <= '0;
				slot_q <= '0;
				mid_q  <= lwgh_pkg::SLOT_W'(lwgh_pkg::WINDOW - lwgh_pkg::HALF);
			end else if (in_scan) begin
				cnt_q  <= cnt_q + 1'b1;
				slot_q <= (slot_q == lwgh_pkg::SLOT_W'(lwgh_pkg::WINDOW - 1)) ?
					'0 : slot_q + 1'b1;
				mid_q  <= (mid_q == lwgh_pkg::SLOT_W'(lwgh_pkg::WINDOW - 1)) ?
					'0 : mid_q + 1'b1;
			end
		end
	end

	// read-first: the partner slot is the one being overwritten
	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= mem[slot_q];
			mid_s1   <= mem[mid_q];
			if (in_scan) begin
				mem[slot_q] <= range_mm;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= last_in_scan;
			pair_s1   <= pair;
			idx_s1    <= lwgh_pkg::IDX_W'(cnt_q - lwgh_pkg::CNT_W'(lwgh_pkg::WINDOW));
			sample_s1 <= range_mm;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lwgh_pkg::CNT_W'(lwgh_pkg::MAX_SCAN))
		else $error("scan counter past limit");
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < lwgh_pkg::SLOT_W'(lwgh_pkg::WINDOW) && mid_q < lwgh_pkg::SLOT_W'(lwgh_pkg::WINDOW))
		else $error("delay line address out of range");
	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_in_scan |=> cnt_q == '0 && slot_q == '0)
		else $error("scan state not cleared after last word");
`endif

endmodule

### rtl/lwgh_track.sv
// ----------------------------------------------------------------------------
// lwgh_track
// forms the range product of each pair and, while cos_pos is set, keeps the best pair of the scan
// ----------------------------------------------------------------------------
module lwgh_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          cos_pos,
	input  lwgh_pkg::samp_t               samp_s1,
	input  logic [lwgh_pkg::RANGE_W-1:0]  first_s1,
	input  logic [lwgh_pkg::RANGE_W-1:0]  mid_s1,
	output lwgh_pkg::res_t                res_s3
);

	logic                         valid_s2;
	logic                         last_s2;
	logic                         pair_s2;
	logic [lwgh_pkg::IDX_W-1:0]   idx_s2;
	logic [lwgh_pkg::PROD_W-1:0]  prod_s2;
	logic [lwgh_pkg::RANGE_W-1:0] mid_s2;

	logic [lwgh_pkg::PROD_W-1:0]  best_prod_q;
	logic [lwgh_pkg::IDX_W-1:0]   best_idx_q;
	logic [lwgh_pkg::RANGE_W-1:0] best_mid_q;
	logic                         found_q;

	logic                         upd;
	logic [lwgh_pkg::PROD_W-1:0]  nxt_prod;
	logic [lwgh_pkg::IDX_W-1:0]   nxt_idx;
	logic [lwgh_pkg::RANGE_W-1:0] nxt_mid;
	logic                         nxt_found;

	logic                         valid_s3;
	logic                         found_s3;
	logic [lwgh_pkg::IDX_W-1:0]   idx_s3;
	logic [lwgh_pkg::RANGE_W-1:0] mid_s3;

	assign res_s3 = {valid_s3, found_s3, idx_s3, mid_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= samp_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && samp_s1.valid) begin
			last_s2 <= samp_s1.last;
			pair_s2 <= samp_s1.pair;
			idx_s2  <= samp_s1.idx;
			mid_s2  <= mid_s1;
			prod_s2 <= lwgh_pkg::PROD_W'(first_s1) * lwgh_pkg::PROD_W'(samp_s1.sample);
		end
	end

	always_comb begin
		upd       = valid_s2 && pair_s2 && cos_pos && (prod_s2 > best_prod_q);
		nxt_prod  = upd ? prod_s2 : best_prod_q;
		nxt_idx   = upd ? idx_s2 : best_idx_q;
		nxt_mid   = upd ? mid_s2 : best_mid_q;
		nxt_found = upd | found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_prod_q <= '0;
			best_idx_q  <= '0;
			best_mid_q  <= '0;
			found_q     <= 1'b0;
		end else if (en && valid_s2) begin
			if (last_s2) begin
				best_prod_q <= '0;
				best_idx_q  <= '0;
				best_mid_q  <= '0;
				found_q     <= 1'b0;
			end else begin
				best_prod_q <= nxt_prod;
				best_idx_q  <= nxt_idx;
				best_mid_q  <= nxt_mid;
				found_q     <= nxt_found;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2 && last_s2) begin
			found_s3 <= nxt_found;
			idx_s3   <= nxt_idx;
			mid_s3   <= nxt_mid;
		end
	end

`ifndef SYNTH
	a_found_prod: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> best_prod_q == '0)
		else $error("best product kept without a found pair");
`endif

endmodule

### rtl/lwgh_head.sv
// ----------------------------------------------------------------------------
// lwgh_head
// turns the kept pair into a heading: index scaling, offset, sign and
// saturation, with the output word register
// ----------------------------------------------------------------------------
module lwgh_head (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lwgh_pkg::cfg_t              cfg,
	input  lwgh_pkg::res_t              res_s3,
	input  logic                        out_ready,
	output logic                        en,
	output logic                        out_valid,
	output logic [lwgh_pkg::OUT_W-1:0]  steer_angle,
	output logic                        pair_found
);

	logic                               valid_s4;
	logic                               found_s4;
	logic                               neg_s4;
	logic [lwgh_pkg::MULT_W-1:0]        mult_s4;
	logic [lwgh_pkg::HSUM_W-1:0]        hsum;
	logic signed [lwgh_pkg::HEAD_W-1:0] head;
	logic signed [lwgh_pkg::HEAD_W-1:0] head_sgn;
	logic signed [lwgh_pkg::HEAD_W-1:0] head_sat;

	// stall only when a result meets a full output register
	assign en   = !(valid_s4 && out_valid && !out_ready);
	assign hsum = lwgh_pkg::HSUM_W'(res_s3.idx) + lwgh_pkg::HSUM_W'(lwgh_pkg::HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= res_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_s3.valid) begin
			found_s4 <= res_s3.found;
			neg_s4   <= res_s3.mid < cfg.clear_range;
			mult_s4  <= lwgh_pkg::MULT_W'(hsum) * lwgh_pkg::MULT_W'(cfg.angle_step);
		end
	end

	always_comb begin
		head = '0;
		if (found_s4) begin
			head = $signed({{(lwgh_pkg::HEAD_W-lwgh_pkg::AMIN_W){cfg.base_angle[lwgh_pkg::AMIN_W-1]}},
				cfg.base_angle})
				+ $signed({{(lwgh_pkg::HEAD_W-lwgh_pkg::MULT_W){1'b0}}, mult_s4});
		end
		head_sgn = neg_s4 ? -head : head;
		if (head_sgn > lwgh_pkg::SAT_MAX) begin
			head_sat = lwgh_pkg::SAT_MAX;
		end else if (head_sgn < lwgh_pkg::SAT_MIN) begin
			head_sat = lwgh_pkg::SAT_MIN;
		end else begin
			head_sat = head_sgn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en && valid_s4) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s4) begin
			steer_angle <= head_sat[lwgh_pkg::OUT_W-1:0];
			pair_found  <= found_s4;
		end
	end

endmodule

### rtl/lidar_widest_gap_heading_core.sv
// ----------------------------------------------------------------------------
// lidar_widest_gap_heading_core
// streams lidar range samples, pairs each with the sample one window back,
// keeps the pair with the largest range product, if cos_pos is set, and emits its heading at
// the end of each scan
//
//   channel   direction   handshake            payload
//   in        to core     in_valid/in_ready    range_mm, last_in_scan
//   out       from core   out_valid/out_ready  steer_angle, pair_found
//   cfg       to core     cfg_we               cfg_index, cfg_data
//
// one sample per cycle while in_ready is high; the delay line is a 300-word ram read at two ports
// result word of a scan moves through registers s1, s2, s3, s4 and the output register
// no clearing pass after reset: delay line words read before they are written are never used
// input stalls only while a result waits and another result reaches the end
// ----------------------------------------------------------------------------
module lidar_widest_gap_heading_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lwgh_pkg::RANGE_W-1:0]  range_mm,
	input  logic                          last_in_scan,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lwgh_pkg::OUT_W-1:0]    steer_angle,
	output logic                          pair_found,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [lwgh_pkg::CFG_W-1:0]    cfg_data
);

	lwgh_pkg::cfg_t               cfg_q;
	lwgh_pkg::samp_t              samp_s1;
	lwgh_pkg::res_t               res_s3;
	logic [lwgh_pkg::RANGE_W-1:0] first_s1;
	logic [lwgh_pkg::RANGE_W-1:0] mid_s1;
	logic                         en;
	logic                         accept;

	assign in_ready = en;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_angle  <= lwgh_pkg::AMIN_RST;
			cfg_q.angle_step  <= lwgh_pkg::STEP_RST;
			cfg_q.clear_range <= lwgh_pkg::SAFE_RST;
			cfg_q.cos_pos     <= 1'b1;
		end else if (cfg_we) begin
			unique case (lwgh_pkg::cfg_idx_t'(cfg_index))
				lwgh_pkg::CFG_BASE_ANGLE: begin
					cfg_q.base_angle <= cfg_data[lwgh_pkg::AMIN_W-1:0];
				end
				lwgh_pkg::CFG_ANGLE_STEP: begin
					cfg_q.angle_step <= cfg_data[lwgh_pkg::STEP_W-1:0];
				end
				lwgh_pkg::CFG_SAFE_DIST: begin
					cfg_q.clear_range <= cfg_data[lwgh_pkg::RANGE_W-1:0];
				end
				lwgh_pkg::CFG_COS_POS: begin
					cfg_q.cos_pos <= cfg_data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	lwgh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.accept       (accept),
		.range_mm     (range_mm),
		.last_in_scan (last_in_scan),
		.samp_s1      (samp_s1),
		.first_s1     (first_s1),
		.mid_s1       (mid_s1)
	);

	lwgh_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cos_pos  (cfg_q.cos_pos),
		.samp_s1  (samp_s1),
		.first_s1 (first_s1),
		.mid_s1   (mid_s1),
		.res_s3   (res_s3)
	);

	lwgh_head u_head (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.res_s3      (res_s3),
		.out_ready   (out_ready),
		.en          (en),
		.out_valid   (out_valid),
		.steer_angle (steer_angle),
		.pair_found  (pair_found)
	);

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");
`endif

endmodule
